@@ hdl/request_header_stream_parser_macros.svh @@
// Assertion macros for the request header stream parser.
// Used by the top level; expects clk and arst_n in the enclosing module.
`ifndef REQUEST_HEADER_STREAM_PARSER_MACROS_SVH
`define REQUEST_HEADER_STREAM_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define RHSP_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define RHSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RHSP_ASSERT(lbl, ante, cons, msg)
`define RHSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/rhsp_pkg.sv @@
// Shared types and codes for the request header stream parser.
// No dependencies.
`timescale 1ns / 1ps

package rhsp_pkg;

	// input item kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// token classes
	localparam logic [2:0] CLS_METHOD   = 3'd0;
	localparam logic [2:0] CLS_PROTOCOL = 3'd1;
	localparam logic [2:0] CLS_VERSION  = 3'd2;
	localparam logic [2:0] CLS_KEY      = 3'd3;
	localparam logic [2:0] CLS_VALUE    = 3'd4;
	localparam logic [2:0] CLS_DELIM    = 3'd5;
	localparam logic [2:0] CLS_IGNORED  = 3'd6;

	// status codes
	localparam logic [3:0] ST_BUSY       = 4'd0;
	localparam logic [3:0] ST_DONE       = 4'd1;
	localparam logic [3:0] ST_BAD_FIRST  = 4'd2;
	localparam logic [3:0] ST_BAD_EOL    = 4'd3;
	localparam logic [3:0] ST_LINE_LONG  = 4'd4;
	localparam logic [3:0] ST_EMPTY_KEY  = 4'd5;
	localparam logic [3:0] ST_NO_COLON   = 4'd6;
	localparam logic [3:0] ST_TOO_MANY   = 4'd7;
	localparam logic [3:0] ST_KEY_LONG   = 4'd8;
	localparam logic [3:0] ST_EARLY_END  = 4'd9;

	// characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [3:0] CFG_RESET = 4'd5;

	// one result item
	typedef struct packed {
		logic [7:0] data;
		logic [2:0] cls;
		logic [2:0] slot;
		logic [3:0] status;
		logic [3:0] stored;
	} rhsp_result_t;

endpackage

@@ hdl/request_header_stream_parser.sv @@
// Request header stream parser: checks the request line and header lines one
// byte per item, tags each byte with its token class and tracks distinct keys.
//
// Input channel (in_valid/in_stall): kind selects data byte, start of a new
// request or end of input; byte_in carries the data byte. One item is taken in
// every cycle while in_stall is low; in_stall rises only when both entries of
// the output buffer are held.
// Output channel (out_valid/out_stall): one result item per input item, in
// order: echoed byte, token class, key slot, status after the item and the
// number of distinct keys. Each result is registered in the output buffer before out_valid.
// Throughput is one item per cycle while in_stall is low; the key compare runs on all slots in
// parallel against a byte prefetched from each slot's bank when the previous item was taken.
// Stalling the output fills a two-entry buffer, then the input stalls; no item
// is lost or repeated.
// Reset (arst_n low) clears parse state and the buffer and sets the key limit
// register to 5; key contents are not cleared. cfg_wr_en writes the limit
// register; the user must assert it only while the block is idle, as the block does not enforce this.
// Depends on rhsp_pkg, rhsp_key_store, rhsp_out_fifo and the macros header.
`timescale 1ns / 1ps
`include "request_header_stream_parser_macros.svh"

module request_header_stream_parser
	import rhsp_pkg::*;
#(
	parameter int LINE_BYTES = 2046,
	parameter int KEY_SLOTS  = 8,
	parameter int KEY_BYTES  = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] byte_out,
	output logic [2:0] token_class,
	output logic [2:0] field_slot,
	output logic [3:0] status,
	output logic [3:0] fields_stored
);

	localparam int SW  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int CW  = $clog2(KEY_SLOTS + 1);
	localparam int AW  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int KLW = $clog2(KEY_BYTES + 1);
	localparam int LW  = $clog2(LINE_BYTES + 1);

	typedef enum logic [3:0] {
		PH_METHOD,
		PH_PROTOCOL,
		PH_VERSION,
		PH_FIRST_LF,
		PH_KEY_START,
		PH_KEY,
		PH_VALUE_FIRST,
		PH_VALUE,
		PH_HDR_LF,
		PH_END_LF,
		PH_OVER
	} phase_t;

	phase_t               phase_q, nxt_phase;
	logic [LW-1:0]        line_len_q, nxt_line_len;
	logic [KLW-1:0]       key_len_q, nxt_key_len;
	logic [KEY_SLOTS-1:0] match_q, nxt_match;
	logic [CW-1:0]        dcount_q, nxt_dcount;
	logic [3:0]           sticky_q, nxt_sticky;
	logic [SW-1:0]        slot_q, nxt_slot;
	logic [3:0]           cfg_max_q;

	logic                 accept;
	logic                 fifo_full;
	rhsp_result_t         res;
	rhsp_result_t         out_data;

	logic                 key_wr, len_wr;
	logic [KLW-1:0]       kl_use;
	logic [KEY_SLOTS-1:0] match_base, match_after, valid_vec;
	logic [KEY_SLOTS-1:0] hit_vec, len_eq_vec, found_vec;
	logic                 found_any;
	logic [SW-1:0]        found_idx;
	logic                 limit_hit;
	logic                 is_letter, is_digit;
	logic [SW-1:0]        res_slot;
	logic [AW-1:0]        rd_addr;

	assign accept   = in_valid && !in_stall;
	assign in_stall = fifo_full;

	// per-slot helpers for the key compare and close
	always_comb begin
		kl_use     = (phase_q == PH_KEY_START) ? '0 : key_len_q;
		match_base = (phase_q == PH_KEY_START) ? '1 : match_q;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			valid_vec[i] = (32'(i) < 32'(dcount_q));
		end
		match_after = match_base & ~(valid_vec & ~hit_vec);
		found_vec   = match_q & valid_vec & len_eq_vec;
		found_any   = |found_vec;
		found_idx   = '0;
		for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
			if (found_vec[i]) found_idx = SW'(i);
		end
		limit_hit = (32'(dcount_q) >= 32'(cfg_max_q)) || (32'(dcount_q) >= 32'(KEY_SLOTS));
		is_letter = ((byte_in >= 8'h41) && (byte_in <= 8'h5A)) ||
			((byte_in >= 8'h61) && (byte_in <= 8'h7A));
		is_digit  = (byte_in >= 8'h30) && (byte_in <= 8'h39);
	end

	// next parse state and result for one item
	always_comb begin
		nxt_phase    = phase_q;
		nxt_line_len = line_len_q;
		nxt_key_len  = key_len_q;
		nxt_match    = match_q;
		nxt_dcount   = dcount_q;
		nxt_sticky   = sticky_q;
		nxt_slot     = slot_q;
		key_wr       = 1'b0;
		len_wr       = 1'b0;
		res.data     = 8'd0;
		res.cls      = CLS_IGNORED;
		res_slot     = '0;

		if (kind == KIND_START) begin
			nxt_phase    = PH_METHOD;
			nxt_line_len = '0;
			nxt_key_len  = '0;
			nxt_match    = '1;
			nxt_dcount   = '0;
			nxt_sticky   = ST_BUSY;
			nxt_slot     = '0;
		end else if (kind == KIND_END) begin
			if (sticky_q == ST_BUSY) begin
				nxt_sticky = ST_EARLY_END;
				nxt_phase  = PH_OVER;
			end
		end else if (kind == KIND_DATA) begin
			res.data = byte_in;
			if (phase_q == PH_FIRST_LF || phase_q == PH_HDR_LF || phase_q == PH_END_LF) begin
				// expecting the LF of a CR LF pair
				if (byte_in != CH_LF) begin
					nxt_sticky = ST_BAD_EOL;
					nxt_phase  = PH_OVER;
				end else begin
					res.cls      = CLS_DELIM;
					nxt_line_len = '0;
					if (phase_q == PH_END_LF) begin
						nxt_sticky = ST_DONE;
						nxt_phase  = PH_OVER;
					end else begin
						nxt_phase = PH_KEY_START;
					end
				end
			end else if (phase_q != PH_OVER) begin
				if (byte_in == CH_LF) begin
					nxt_sticky = ST_BAD_EOL;
					nxt_phase  = PH_OVER;
				end else if (byte_in == CH_CR) begin
					// line end, legal only in some phases
					case (phase_q)
						PH_METHOD, PH_PROTOCOL: begin
							nxt_sticky = ST_BAD_FIRST;
							nxt_phase  = PH_OVER;
						end
						PH_VERSION: begin
							res.cls   = CLS_DELIM;
							nxt_phase = PH_FIRST_LF;
						end
						PH_KEY_START: begin
							res.cls   = CLS_DELIM;
							nxt_phase = PH_END_LF;
						end
						PH_KEY: begin
							nxt_sticky = ST_NO_COLON;
							nxt_phase  = PH_OVER;
						end
						default: begin
							res.cls   = CLS_DELIM;
							nxt_phase = PH_HDR_LF;
						end
					endcase
				end else if (32'(line_len_q) >= 32'(LINE_BYTES)) begin
					nxt_sticky = ST_LINE_LONG;
					nxt_phase  = PH_OVER;
				end else begin
					nxt_line_len = line_len_q + LW'(1);
					case (phase_q)
						PH_METHOD: begin
							if (is_letter) begin
								res.cls = CLS_METHOD;
							end else if (byte_in == CH_SPACE) begin
								res.cls   = CLS_DELIM;
								nxt_phase = PH_PROTOCOL;
							end else begin
								nxt_sticky = ST_BAD_FIRST;
								nxt_phase  = PH_OVER;
							end
						end
						PH_PROTOCOL: begin
							if (byte_in == CH_SLASH) begin
								res.cls   = CLS_DELIM;
								nxt_phase = PH_VERSION;
							end else begin
								res.cls = CLS_PROTOCOL;
							end
						end
						PH_VERSION: begin
							if (is_digit || byte_in == CH_DOT) begin
								res.cls = CLS_VERSION;
							end else begin
								nxt_sticky = ST_BAD_FIRST;
								nxt_phase  = PH_OVER;
							end
						end
						PH_KEY_START, PH_KEY: begin
							if (byte_in == CH_COLON && phase_q == PH_KEY_START) begin
								nxt_sticky = ST_EMPTY_KEY;
								nxt_phase  = PH_OVER;
							end else if (byte_in == CH_COLON) begin
								// close the key: reuse a matching slot or take a new one
								if (found_any) begin
									nxt_slot  = found_idx;
									res.cls   = CLS_DELIM;
									res_slot  = found_idx;
									nxt_phase = PH_VALUE_FIRST;
								end else if (limit_hit) begin
									nxt_sticky = ST_TOO_MANY;
									nxt_phase  = PH_OVER;
								end else begin
									len_wr     = 1'b1;
									nxt_slot   = dcount_q[SW-1:0];
									nxt_dcount = dcount_q + CW'(1);
									res.cls    = CLS_DELIM;
									res_slot   = dcount_q[SW-1:0];
									nxt_phase  = PH_VALUE_FIRST;
								end
							end else if (32'(kl_use) >= 32'(KEY_BYTES)) begin
								nxt_sticky = ST_KEY_LONG;
								nxt_phase  = PH_OVER;
							end else begin
								// key byte: narrow the match set and store it
								nxt_match   = match_after;
								key_wr      = (32'(dcount_q) < 32'(KEY_SLOTS));
								nxt_key_len = kl_use + KLW'(1);
								res.cls     = CLS_KEY;
								nxt_phase   = PH_KEY;
							end
						end
						PH_VALUE_FIRST: begin
							nxt_phase = PH_VALUE;
							if (byte_in != CH_SPACE) begin
								res.cls  = CLS_VALUE;
								res_slot = slot_q;
							end
						end
						default: begin
							res.cls  = CLS_VALUE;
							res_slot = slot_q;
						end
					endcase
				end
			end
		end

		res.slot   = 3'(res_slot);
		res.status = nxt_sticky;
		res.stored = 4'(nxt_dcount);
	end

	// prefetch address: position of the next key byte
	always_comb begin
		if (nxt_phase == PH_KEY && (32'(nxt_key_len) < 32'(KEY_BYTES))) begin
			rd_addr = nxt_key_len[AW-1:0];
		end else begin
			rd_addr = '0;
		end
	end

	// parse state and limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_METHOD;
			line_len_q <= '0;
			key_len_q  <= '0;
			match_q    <= '1;
			dcount_q   <= '0;
			sticky_q   <= ST_BUSY;
			slot_q     <= '0;
			cfg_max_q  <= CFG_RESET;
		end else begin
			if (cfg_wr_en) begin
				cfg_max_q <= cfg_wr_data;
			end
			if (accept) begin
				phase_q    <= nxt_phase;
				line_len_q <= nxt_line_len;
				key_len_q  <= nxt_key_len;
				match_q    <= nxt_match;
				dcount_q   <= nxt_dcount;
				sticky_q   <= nxt_sticky;
				slot_q     <= nxt_slot;
			end
		end
	end

	rhsp_key_store #(
		.KEY_SLOTS (KEY_SLOTS),
		.KEY_BYTES (KEY_BYTES)
	) u_keys (
		.clk        (clk),
		.wr_slot    (dcount_q[SW-1:0]),
		.wr_en      (accept && key_wr),
		.wr_addr    (kl_use[AW-1:0]),
		.wr_data    (byte_in),
		.len_wr_en  (accept && len_wr),
		.len_wr_val (key_len_q),
		.rd_en      (accept),
		.rd_addr    (rd_addr),
		.cmp_byte   (byte_in),
		.cmp_len    (kl_use),
		.hit_vec    (hit_vec),
		.len_eq_vec (len_eq_vec)
	);

	rhsp_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (fifo_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign byte_out      = out_data.data;
	assign token_class   = out_data.cls;
	assign field_slot    = out_data.slot;
	assign status        = out_data.status;
	assign fields_stored = out_data.stored;

	// checks
	`RHSP_ASSERT(a_dcount_range, 1'b1, 32'(dcount_q) <= 32'(KEY_SLOTS), "key count overflow")
	`RHSP_ASSERT(a_sticky_over, sticky_q != ST_BUSY, phase_q == PH_OVER, "status set while parsing")
	`RHSP_ASSERT(a_stall_pending, in_stall, out_valid, "input stalled with no result pending")
	`RHSP_ASSERT_NEXT(a_start_clears, accept && kind == KIND_START,
		phase_q == PH_METHOD && dcount_q == '0 && sticky_q == ST_BUSY, "start did not clear")

endmodule

@@ hdl/rhsp_key_store.sv @@
// Key store: one byte bank per slot with registered prefetch reads, slot lengths,
// and the per-slot compare against the incoming key byte. Uses rhsp_pkg.
`timescale 1ns / 1ps

module rhsp_key_store
	import rhsp_pkg::*;
#(
	parameter int KEY_SLOTS = 8,
	parameter int KEY_BYTES = 32,
	localparam int SW  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1,
	localparam int AW  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1,
	localparam int KLW = $clog2(KEY_BYTES + 1)
) (
	input  logic                 clk,
	input  logic [SW-1:0]        wr_slot,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [7:0]           wr_data,
	input  logic                 len_wr_en,
	input  logic [KLW-1:0]       len_wr_val,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	input  logic [7:0]           cmp_byte,
	input  logic [KLW-1:0]       cmp_len,
	output logic [KEY_SLOTS-1:0] hit_vec,
	output logic [KEY_SLOTS-1:0] len_eq_vec
);

	logic [KLW-1:0] len_q [KEY_SLOTS];
	logic [7:0]     rd_q  [KEY_SLOTS];

	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_bank
		logic [7:0] mem_q [KEY_BYTES];

		// byte bank: one write, one prefetch read for the next key byte
		always_ff @(posedge clk) begin
			if (wr_en && (wr_slot == SW'(g))) begin
				mem_q[wr_addr] <= wr_data;
			end
			if (rd_en) begin
				rd_q[g] <= mem_q[rd_addr];
			end
		end

		// stored key length
		always_ff @(posedge clk) begin
			if (len_wr_en && (wr_slot == SW'(g))) begin
				len_q[g] <= len_wr_val;
			end
		end

		// byte still inside the stored key and equal
		assign hit_vec[g]    = (len_q[g] > cmp_len) && (rd_q[g] == cmp_byte);
		assign len_eq_vec[g] = (len_q[g] == cmp_len);
	end

endmodule

@@ hdl/rhsp_out_fifo.sv @@
// Two-entry output buffer that lets the parser take an item while a result waits.
// Uses rhsp_result_t from rhsp_pkg.
`timescale 1ns / 1ps

module rhsp_out_fifo
	import rhsp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  rhsp_result_t push_data,
	output logic         full,
	output logic         out_valid,
	input  logic         out_stall,
	output rhsp_result_t out_data
);

	rhsp_result_t ent_q [2];
	logic         rd_ptr_q;
	logic         wr_ptr_q;
	logic [1:0]   cnt_q;
	logic         pop;

	assign pop       = out_valid && !out_stall;
	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign out_data  = ent_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ tb/tb_request_header_stream_parser.sv @@
// Self-checking testbench for request_header_stream_parser: directed rows, then random
// requests under several key limits, with a shadow parser predicting each result item that no typed row gives.
// Depends on rhsp_pkg and the request_header_stream_parser RTL.
`timescale 1ns / 1ps

module tb_request_header_stream_parser;
	import rhsp_pkg::*;

	localparam int LINE_BYTES     = 2046;
	localparam int KEY_SLOTS      = 8;
	localparam int KEY_BYTES      = 32;
	localparam int RANDOM_ITEMS   = 1700;
	localparam int LONG_HOLD      = 150;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 2000;

	// kind 3 is not a defined operation; the block must ignore it
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef enum logic [3:0] {
		P_METHOD, P_PROTOCOL, P_VERSION, P_FIRST_LF, P_KEY_START, P_KEY,
		P_VALUE_FIRST, P_VALUE, P_HDR_LF, P_END_LF, P_OVER
	} parse_phase_t;

	typedef enum int {FLT_LF, FLT_CR, FLT_COLON, FLT_END, FLT_START, FLT_BYTE} fault_t;

	typedef struct packed {
		logic [1:0]   k;
		logic [7:0]   b;
		logic         typed;
		rhsp_result_t want;
	} dir_row_t;

	localparam int DIR_ROWS = 32;

	// directed rows; typed rows carry their expected item, the rest use the shadow parser
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{KIND_END,   8'h00,    1'b1, '{8'h00, CLS_IGNORED, 3'd0, ST_EARLY_END, 4'd0}},
		'{KIND_DATA,  8'hFF,    1'b1, '{8'hFF, CLS_IGNORED, 3'd0, ST_EARLY_END, 4'd0}},
		'{KIND_SPARE, 8'h00,    1'b1, '{8'h00, CLS_IGNORED, 3'd0, ST_EARLY_END, 4'd0}},
		'{KIND_START, 8'h00,    1'b1, '{8'h00, CLS_IGNORED, 3'd0, ST_BUSY, 4'd0}},
		'{KIND_DATA,  CH_COLON, 1'b1, '{CH_COLON, CLS_IGNORED, 3'd0, ST_BAD_FIRST, 4'd0}},
		'{KIND_START, 8'h00,    1'b1, '{8'h00, CLS_IGNORED, 3'd0, ST_BUSY, 4'd0}},
		'{KIND_DATA,  CH_LF,    1'b1, '{CH_LF, CLS_IGNORED, 3'd0, ST_BAD_EOL, 4'd0}},
		'{KIND_START, 8'h00,    1'b1, '{8'h00, CLS_IGNORED, 3'd0, ST_BUSY, 4'd0}},
		'{KIND_DATA,  "Z",      1'b0, '0},
		'{KIND_DATA,  CH_SPACE, 1'b0, '0},
		'{KIND_DATA,  8'hFF,    1'b0, '0},
		'{KIND_DATA,  CH_SLASH, 1'b0, '0},
		'{KIND_DATA,  "1",      1'b0, '0},
		'{KIND_DATA,  CH_DOT,   1'b0, '0},
		'{KIND_DATA,  CH_CR,    1'b0, '0},
		'{KIND_DATA,  CH_LF,    1'b0, '0},
		'{KIND_DATA,  "k",      1'b0, '0},
		'{KIND_DATA,  CH_COLON, 1'b0, '0},
		'{KIND_DATA,  CH_SPACE, 1'b0, '0},
		'{KIND_DATA,  8'h00,    1'b0, '0},
		'{KIND_DATA,  CH_CR,    1'b0, '0},
		'{KIND_DATA,  CH_LF,    1'b0, '0},
		'{KIND_DATA,  CH_CR,    1'b0, '0},
		'{KIND_DATA,  CH_LF,    1'b0, '0},
		'{KIND_DATA,  "x",      1'b0, '0},
		'{KIND_END,   8'h00,    1'b0, '0},
		'{KIND_START, 8'h00,    1'b1, '{8'h00, CLS_IGNORED, 3'd0, ST_BUSY, 4'd0}},
		'{KIND_DATA,  CH_SPACE, 1'b0, '0},
		'{KIND_DATA,  CH_SLASH, 1'b0, '0},
		'{KIND_DATA,  CH_CR,    1'b0, '0},
		'{KIND_DATA,  CH_LF,    1'b0, '0},
		'{KIND_DATA,  CH_COLON, 1'b1, '{CH_COLON, CLS_IGNORED, 3'd0, ST_EMPTY_KEY, 4'd0}}
	};

	localparam logic [3:0] LIMIT_PLAN [8] = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd7, 4'd2, 4'd5};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [3:0] cfg_wr_data = 4'd0;
	logic       in_valid = 1'b0;
	logic [1:0] kind = KIND_DATA;
	logic [7:0] byte_in = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] byte_out;
	logic [2:0] token_class;
	logic [2:0] field_slot;
	logic [3:0] status;
	logic [3:0] fields_stored;

	// shadow parser state
	parse_phase_t         sh_phase;
	int                   sh_line_len;
	int                   sh_key_len;
	logic [KEY_SLOTS-1:0] sh_match;
	int                   sh_distinct;
	logic [3:0]           sh_status;
	logic [2:0]           sh_slot;
	logic [7:0]           sh_keys [KEY_SLOTS][KEY_BYTES];
	int                   sh_key_lens [KEY_SLOTS];
	logic [3:0]           sh_limit;

	rhsp_result_t tag_queue [$];
	int           items_sent = 0;
	int           results_seen = 0;
	int           fail_count = 0;
	int           tx_calm = 0;
	int           rx_calm = 0;
	int           rx_hold = 0;
	int           next_hold_at = 400;
	int           idle_cycles = 0;
	int           byte_idx;
	int           fault_at;
	fault_t       fault_sel;

	request_header_stream_parser #(
		.LINE_BYTES(LINE_BYTES),
		.KEY_SLOTS(KEY_SLOTS),
		.KEY_BYTES(KEY_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.byte_in(byte_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.byte_out(byte_out),
		.token_class(token_class),
		.field_slot(field_slot),
		.status(status),
		.fields_stored(fields_stored)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Shadow parser
	// ---------------------------------------------------------------
	function automatic void clear_request();
		sh_phase = P_METHOD;
		sh_line_len = 0;
		sh_key_len = 0;
		sh_match = '1;
		sh_distinct = 0;
		sh_status = ST_BUSY;
		sh_slot = 3'd0;
	endfunction

	function automatic void fail_with(input logic [3:0] code);
		sh_status = code;
		sh_phase = P_OVER;
	endfunction

	// adds one key byte, narrowing the candidate slots; 0 on key long
	function automatic bit take_key(input logic [7:0] b);
		if (sh_key_len >= KEY_BYTES) begin
			fail_with(ST_KEY_LONG);
			return 1'b0;
		end
		for (int i = 0; i < sh_distinct; i++)
			if (sh_key_lens[i] <= sh_key_len || sh_keys[i][sh_key_len] != b)
				sh_match[i] = 1'b0;
		if (sh_distinct < KEY_SLOTS)
			sh_keys[sh_distinct][sh_key_len] = b;
		sh_key_len++;
		return 1'b1;
	endfunction

	function automatic rhsp_result_t classify_item(input logic [1:0] k, input logic [7:0] b);
		rhsp_result_t r;
		int lim;
		bit found;
		r = '0;
		r.cls = CLS_IGNORED;
		lim = (sh_limit > KEY_SLOTS) ? KEY_SLOTS : int'(sh_limit);
		if (k == KIND_START) begin
			clear_request();
		end else if (k == KIND_END) begin
			if (sh_status == ST_BUSY)
				fail_with(ST_EARLY_END);
		end else if (k == KIND_DATA) begin
			r.data = b;
			if (sh_phase == P_FIRST_LF || sh_phase == P_HDR_LF || sh_phase == P_END_LF) begin
				// only LF may follow a CR
				if (b != CH_LF) begin
					fail_with(ST_BAD_EOL);
				end else begin
					r.cls = CLS_DELIM;
					sh_line_len = 0;
					if (sh_phase == P_END_LF) begin
						sh_status = ST_DONE;
						sh_phase = P_OVER;
					end else begin
						sh_phase = P_KEY_START;
					end
				end
			end else if (sh_phase != P_OVER) begin
				if (b == CH_LF) begin
					fail_with(ST_BAD_EOL);
				end else if (b == CH_CR) begin
					case (sh_phase)
						P_METHOD, P_PROTOCOL: fail_with(ST_BAD_FIRST);
						P_VERSION: begin
							r.cls = CLS_DELIM;
							sh_phase = P_FIRST_LF;
						end
						P_KEY_START: begin
							r.cls = CLS_DELIM;
							sh_phase = P_END_LF;
						end
						P_KEY: fail_with(ST_NO_COLON);
						default: begin
							r.cls = CLS_DELIM;
							sh_phase = P_HDR_LF;
						end
					endcase
				end else if (sh_line_len >= LINE_BYTES) begin
					fail_with(ST_LINE_LONG);
				end else begin
					sh_line_len++;
					case (sh_phase)
						P_METHOD: begin
							if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
								r.cls = CLS_METHOD;
							end else if (b == CH_SPACE) begin
								r.cls = CLS_DELIM;
								sh_phase = P_PROTOCOL;
							end else begin
								fail_with(ST_BAD_FIRST);
							end
						end
						P_PROTOCOL: begin
							if (b == CH_SLASH) begin
								r.cls = CLS_DELIM;
								sh_phase = P_VERSION;
							end else begin
								r.cls = CLS_PROTOCOL;
							end
						end
						P_VERSION: begin
							if ((b >= "0" && b <= "9") || b == CH_DOT)
								r.cls = CLS_VERSION;
							else
								fail_with(ST_BAD_FIRST);
						end
						P_KEY_START: begin
							if (b == CH_COLON) begin
								fail_with(ST_EMPTY_KEY);
							end else begin
								sh_match = '1;
								sh_key_len = 0;
								if (take_key(b)) begin
									r.cls = CLS_KEY;
									sh_phase = P_KEY;
								end
							end
						end
						P_KEY: begin
							if (b == CH_COLON) begin
								// reuse a matching slot, else store a new key if allowed
								found = 1'b0;
								for (int i = 0; i < sh_distinct; i++)
									if (!found && sh_match[i] &&
											sh_key_lens[i] == sh_key_len) begin
										sh_slot = 3'(i);
										found = 1'b1;
									end
								if (!found) begin
									if (sh_distinct >= lim) begin
										fail_with(ST_TOO_MANY);
									end else begin
										sh_key_lens[sh_distinct] = sh_key_len;
										sh_slot = 3'(sh_distinct);
										sh_distinct++;
										found = 1'b1;
									end
								end
								if (found) begin
									r.cls = CLS_DELIM;
									r.slot = sh_slot;
									sh_phase = P_VALUE_FIRST;
								end
							end else if (take_key(b)) begin
								r.cls = CLS_KEY;
							end
						end
						P_VALUE_FIRST: begin
							// one space after the colon is dropped
							sh_phase = P_VALUE;
							if (b != CH_SPACE) begin
								r.cls = CLS_VALUE;
								r.slot = sh_slot;
							end
						end
						default: begin
							r.cls = CLS_VALUE;
							r.slot = sh_slot;
						end
					endcase
				end
			end
		end
		r.status = sh_status;
		r.stored = 4'(sh_distinct);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	// mostly back to back, some short gaps, rare long ones, and calm stretches
	function automatic int idle_len(ref int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 999);
		if (r < 5) begin
			calm = $urandom_range(40, 200);
			return 0;
		end
		if (r < 600)
			return 0;
		if (r < 900)
			return $urandom_range(1, 3);
		if (r < 985)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] any_byte_but(input logic [7:0] x);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_CR || c == CH_LF || c == x);
		return c;
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] base;
		base = $urandom_range(0, 1) ? "A" : "a";
		return base + 8'($urandom_range(0, 25));
	endfunction

	// offer one item, wait for it to be taken, then record what it should produce
	task automatic offer(input logic [1:0] k, input logic [7:0] b, input logic typed,
			input rhsp_result_t typed_tag);
		int gap;
		rhsp_result_t pred;
		gap = idle_len(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		byte_in <= b;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		pred = classify_item(k, b);
		tag_queue.push_back(typed ? typed_tag : pred);
		items_sent++;
	endtask

	// data byte of a request, with an optional fault slipped in ahead of it
	task automatic put_byte(input logic [7:0] b);
		if (byte_idx == fault_at) begin
			case (fault_sel)
				FLT_LF:    offer(KIND_DATA, CH_LF, 1'b0, '0);
				FLT_CR:    offer(KIND_DATA, CH_CR, 1'b0, '0);
				FLT_COLON: offer(KIND_DATA, CH_COLON, 1'b0, '0);
				FLT_END:   offer(KIND_END, 8'($urandom_range(0, 255)), 1'b0, '0);
				FLT_START: offer(KIND_START, 8'($urandom_range(0, 255)), 1'b0, '0);
				default:   offer(KIND_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
			endcase
		end
		byte_idx++;
		offer(KIND_DATA, b, 1'b0, '0);
	endtask

	// one header line; mostly short keys from a tiny alphabet so repeats and prefixes are common
	task automatic put_header(input int vlen);
		int klen;
		int x;
		x = $urandom_range(0, 99);
		klen = (x < 5) ? $urandom_range(KEY_BYTES - 1, KEY_BYTES + 1) : $urandom_range(1, 3);
		for (int i = 0; i < klen; i++)
			put_byte(x < 5 ? rand_letter() :
				x < 12 ? any_byte_but(CH_COLON) : 8'("a" + $urandom_range(0, 2)));
		put_byte(CH_COLON);
		if ($urandom_range(0, 9) < 7)
			put_byte(CH_SPACE);
		repeat (vlen) put_byte(any_byte_but(CH_CR));
		put_byte(CH_CR);
		put_byte(CH_LF);
	endtask

	// a whole request: noise, well formed, or well formed with one fault
	task automatic send_request();
		int r;
		int n;
		r = $urandom_range(0, 99);
		byte_idx = 0;
		fault_at = -1;
		if (r < 10) begin
			n = $urandom_range(3, 15);
			repeat (n) offer(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, '0);
			return;
		end
		if (r < 30) begin
			fault_at = $urandom_range(0, 40);
			fault_sel = fault_t'($urandom_range(0, 5));
		end
		offer(KIND_START, 8'($urandom_range(0, 255)), 1'b0, '0);

		// request line
		repeat ($urandom_range(0, 6)) put_byte(rand_letter());
		put_byte(CH_SPACE);
		repeat ($urandom_range(0, 5)) put_byte(any_byte_but(CH_SLASH));
		put_byte(CH_SLASH);
		repeat ($urandom_range(0, 4)) begin
			n = $urandom_range(0, 10);
			put_byte(n == 10 ? CH_DOT : 8'("0" + n));
		end
		put_byte(CH_CR);
		put_byte(CH_LF);

		// headers
		repeat ($urandom_range(0, 10)) put_header($urandom_range(0, 8));
		put_byte(CH_CR);
		put_byte(CH_LF);
		if ($urandom_range(0, 4) == 0)
			offer(KIND_END, 8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	// key limit is written only once every result has come back
	task automatic set_limit(input logic [3:0] v);
		in_valid <= 1'b0;
		while (tag_queue.size() != 0) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sh_limit = v;
	endtask

	task automatic note_failure(input string what, input rhsp_result_t want,
			input rhsp_result_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s at %0t: expected byte %h class %0d slot %0d status %0d stored %0d,",
				what, $time, want.data, want.cls, want.slot, want.status, want.stored);
			$display("    got byte %h class %0d slot %0d status %0d stored %0d",
				got.data, got.cls, got.slot, got.status, got.stored);
		end
	endtask

	// ---------------------------------------------------------------
	// Result side: check each taken item, then choose the next stall
	// ---------------------------------------------------------------
	always @(posedge clk) begin : result_side
		rhsp_result_t got;
		rhsp_result_t want;
		int gap;
		if (arst_n) begin
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				got = {byte_out, token_class, field_slot, status, fields_stored};
				results_seen++;
				if (tag_queue.size() == 0) begin
					note_failure("unexpected item", '0, got);
				end else begin
					want = tag_queue.pop_front();
					if (got.data !== want.data || got.cls !== want.cls || got.slot !== want.slot ||
							got.status !== want.status || got.stored !== want.stored)
						note_failure("mismatch", want, got);
				end
			end
			// a long hold now and then, so the buffer fills and the input stalls
			if (results_seen >= next_hold_at) begin
				rx_hold = LONG_HOLD;
				next_hold_at += 1100;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else begin
				gap = idle_len(rx_calm);
				rx_hold = (gap > 0) ? gap - 1 : 0;
				out_stall <= (gap > 0);
			end
		end
	end

	// watchdog: no item taken on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin : stimulus
		logic [3:0] lim;
		clear_request();
		sh_limit = CFG_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows under the reset key limit
		for (int i = 0; i < DIR_ROWS; i++)
			offer(DIRECTED[i].k, DIRECTED[i].b, DIRECTED[i].typed, DIRECTED[i].want);

		// random requests, one key limit per phase
		for (int ph = 0; ph < 8; ph++) begin
			lim = (ph == 6) ? 4'($urandom_range(0, 15)) : LIMIT_PLAN[ph];
			set_limit(lim);
			while (items_sent < DIR_ROWS + (ph + 1) * RANDOM_ITEMS / 8)
				send_request();
		end

		in_valid <= 1'b0;
		while (tag_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/rhsp_pkg.sv
hdl/rhsp_key_store.sv
hdl/rhsp_out_fifo.sv
hdl/request_header_stream_parser.sv
tb/tb_request_header_stream_parser.sv
